>>> hw/rtl/hpt_pkg.sv
// Shared types and constants for the homography point transform.
// No dependencies.
`default_nettype none

package hpt_pkg;

  // Coordinate and coefficient width (signed fixed point)
  localparam int unsigned Q_W = 32;
  // Row sum of two 64-bit products plus a shifted offset, signed
  localparam int unsigned SUM_W = 66;
  // Quotient bits produced by the divider
  localparam int unsigned QUO_W = 32;
  // Configuration data and index widths
  localparam int unsigned CFG_W = 64;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R0_AB   = 3'd0,
    CFG_R0C_R1A = 3'd1,
    CFG_R1_BC   = 3'd2,
    CFG_R2_AB   = 3'd3,
    CFG_R2_C    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [Q_W-1:0] h00;
    logic signed [Q_W-1:0] h01;
    logic signed [Q_W-1:0] h02;
    logic signed [Q_W-1:0] h10;
    logic signed [Q_W-1:0] h11;
    logic signed [Q_W-1:0] h12;
    logic signed [Q_W-1:0] h20;
    logic signed [Q_W-1:0] h21;
    logic signed [Q_W-1:0] h22;
  } coef_t;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

>>> hw/rtl/hpt_front.sv
// Front end: products, row sums and classification into divider operands.
// Depends on hpt_pkg.
`default_nettype none

module hpt_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [31:0]          pt_x_i,
  input  wire logic [31:0]          pt_y_i,
  input  wire hpt_pkg::coef_t       coef_i,
  output logic                      valid_o,
  output logic [2*(hpt_pkg::SUM_W+FRAC_BITS)+hpt_pkg::SUM_W+2:0] data_o
);

  localparam int unsigned SW = hpt_pkg::SUM_W;
  localparam int unsigned NW = SW + FRAC_BITS;

  logic v1_q, v2_q, v3_q;
  logic signed [63:0] p00_q, p01_q, p10_q, p11_q, p20_q, p21_q;
  logic signed [SW-1:0] sx_q, sy_q, sw_q;
  logic signed [SW-1:0] sx_d, sy_d, sw_d;
  logic [SW-1:0] ax, ay, aw;
  logic [NW-1:0] nx_d, ny_d, nx_q, ny_q;
  logic [SW-1:0] den_d, den_q;
  logic negx_q, negy_q, wz_q, wz_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: six 32x32 products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= $signed(pt_x_i) * coef_i.h00;
      p01_q <= $signed(pt_y_i) * coef_i.h01;
      p10_q <= $signed(pt_x_i) * coef_i.h10;
      p11_q <= $signed(pt_y_i) * coef_i.h11;
      p20_q <= $signed(pt_x_i) * coef_i.h20;
      p21_q <= $signed(pt_y_i) * coef_i.h21;
    end
  end

  // Stage 2: exact row sums in Q(2F)
  always_comb begin
    sx_d = SW'(p00_q) + SW'(p01_q) + (SW'(coef_i.h02) <<< FRAC_BITS);
    sy_d = SW'(p10_q) + SW'(p11_q) + (SW'(coef_i.h12) <<< FRAC_BITS);
    sw_d = SW'(p20_q) + SW'(p21_q) + (SW'(coef_i.h22) <<< FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      sw_q <= sw_d;
    end
  end

  // Stage 3: magnitudes; zero weight divides by 1.0 to truncate
  always_comb begin
    ax   = sx_q[SW-1] ? SW'(-sx_q) : SW'(sx_q);
    ay   = sy_q[SW-1] ? SW'(-sy_q) : SW'(sy_q);
    aw   = sw_q[SW-1] ? SW'(-sw_q) : SW'(sw_q);
    wz_d = (sw_q == '0);
    if (wz_d) begin
      nx_d  = NW'(ax);
      ny_d  = NW'(ay);
      den_d = SW'(1) << FRAC_BITS;
    end else begin
      nx_d  = NW'(ax) << FRAC_BITS;
      ny_d  = NW'(ay) << FRAC_BITS;
      den_d = aw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q   <= nx_d;
      ny_q   <= ny_d;
      den_q  <= den_d;
      negx_q <= sx_q[SW-1] ^ sw_q[SW-1];
      negy_q <= sy_q[SW-1] ^ sw_q[SW-1];
      wz_q   <= wz_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = {nx_q, ny_q, den_q, negx_q, negy_q, wz_q};

endmodule

`default_nettype wire

>>> hw/rtl/hpt_queue.sv
// Four-entry queue decoupling the front end from the divider back end.
// Depends on hpt_pkg only through its users.
`default_nettype none

module hpt_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  avail_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int unsigned DEPTH = 4;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign full_o  = (cnt_q == 3'(DEPTH));
  assign avail_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule

`default_nettype wire

>>> hw/rtl/hpt_back.sv
// Back end: overflow precheck, 32-stage restoring divider pair, clipping.
// Depends on hpt_pkg.
`default_nettype none

module hpt_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        avail_i,
  input  wire logic [2*(hpt_pkg::SUM_W+FRAC_BITS)+hpt_pkg::SUM_W+2:0] data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      out_x_o,
  output logic [31:0]      out_y_o,
  output logic [31:0]      out_w_o,
  output logic             saturated_o
);

  localparam int unsigned SW = hpt_pkg::SUM_W;
  localparam int unsigned NW = SW + FRAC_BITS;
  localparam int unsigned QW = hpt_pkg::QUO_W;
  localparam int unsigned DW = SW + QW;
  localparam int unsigned NS = QW;

  // {sat, value}
  function automatic logic [QW:0] clip(logic [QW-1:0] q, logic ovf, logic neg);
    logic [QW:0] r;
    if (neg) begin
      if (ovf || q > hpt_pkg::Q_MIN) r = {1'b1, hpt_pkg::Q_MIN};
      else                           r = {1'b0, QW'(-q)};
    end else begin
      if (ovf || q[QW-1]) r = {1'b1, hpt_pkg::Q_MAX};
      else                r = {1'b0, q};
    end
    return r;
  endfunction

  logic en;
  logic [NW-1:0] in_nx, in_ny;
  logic [SW-1:0] in_den;
  logic in_negx, in_negy, in_wz;

  logic          v_q   [NS+1];
  logic [NW-1:0] rx_q  [NS+1];
  logic [NW-1:0] ry_q  [NS+1];
  logic [QW-1:0] qx_q  [NS+1];
  logic [QW-1:0] qy_q  [NS+1];
  logic [SW-1:0] d_q   [NS+1];
  logic          ox_q  [NS+1];
  logic          oy_q  [NS+1];
  logic          nx_q  [NS+1];
  logic          ny_q  [NS+1];
  logic          wz_q  [NS+1];

  logic [NW-1:0] rx_n [NS];
  logic [NW-1:0] ry_n [NS];
  logic          cx   [NS];
  logic          cy   [NS];
  logic [DW-1:0] dsh  [NS];
  logic [DW-1:0] dtop;

  logic [QW:0] cx_out, cy_out;
  logic out_valid_q, sat_q, wz_out_q;
  logic [QW-1:0] ox_out_q, oy_out_q;

  assign {in_nx, in_ny, in_den, in_negx, in_negy, in_wz} = data_i;

  // Whole back end freezes while the output transaction waits
  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && avail_i;
  assign dtop  = DW'(in_den) << QW;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      dsh[k]  = DW'(d_q[k]) << (QW - 1 - k);
      cx[k]   = DW'(rx_q[k]) >= dsh[k];
      cy[k]   = DW'(ry_q[k]) >= dsh[k];
      rx_n[k] = cx[k] ? rx_q[k] - NW'(dsh[k]) : rx_q[k];
      ry_n[k] = cy[k] ? ry_q[k] - NW'(dsh[k]) : ry_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) v_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= pop_o;
      for (int k = 0; k < NS; k++) v_q[k+1] <= v_q[k];
      out_valid_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // quotient of 2^32 or more can only clip
      rx_q[0] <= in_nx;
      ry_q[0] <= in_ny;
      qx_q[0] <= '0;
      qy_q[0] <= '0;
      d_q[0]  <= in_den;
      ox_q[0] <= DW'(in_nx) >= dtop;
      oy_q[0] <= DW'(in_ny) >= dtop;
      nx_q[0] <= in_negx;
      ny_q[0] <= in_negy;
      wz_q[0] <= in_wz;
      for (int k = 0; k < NS; k++) begin
        rx_q[k+1] <= rx_n[k];
        ry_q[k+1] <= ry_n[k];
        qx_q[k+1] <= {qx_q[k][QW-2:0], cx[k]};
        qy_q[k+1] <= {qy_q[k][QW-2:0], cy[k]};
        d_q[k+1]  <= d_q[k];
        ox_q[k+1] <= ox_q[k];
        oy_q[k+1] <= oy_q[k];
        nx_q[k+1] <= nx_q[k];
        ny_q[k+1] <= ny_q[k];
        wz_q[k+1] <= wz_q[k];
      end
    end
  end

  assign cx_out = clip(qx_q[NS], ox_q[NS], nx_q[NS]);
  assign cy_out = clip(qy_q[NS], oy_q[NS], ny_q[NS]);

  always_ff @(posedge clk_i) begin
    if (en && v_q[NS]) begin
      ox_out_q <= cx_out[QW-1:0];
      oy_out_q <= cy_out[QW-1:0];
      sat_q    <= cx_out[QW] | cy_out[QW];
      wz_out_q <= wz_q[NS];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_out_q;
  assign out_y_o     = oy_out_q;
  assign out_w_o     = wz_out_q ? '0 : (32'd1 << FRAC_BITS);
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

>>> hw/rtl/homography_point_transform.sv
// Homography point transform: top level with coefficient registers.
// Depends on hpt_pkg, hpt_front, hpt_queue, hpt_back.
//
// Maps a point (pt_x, pt_y), signed Q16.16 with implied w = 1.0, through a
// 3x3 projective matrix and divides by the resulting w (truncating toward
// zero). Zero w gives the unnormalised x and y with out_w = 0.
// Input channel: in_valid_i / in_stall_o; a transaction completes when valid
//   is high and stall is low. Output channel: out_valid_o / out_stall_i.
// Config channel: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i
//   selects one of five coefficient words; other indices are ignored.
//   Write only while the block is idle.
// Throughput: one point per clock while the output is not stalled. Path:
//   three front stages (products, sums, magnitudes), the queue, the
//   overflow precheck, 32 one-bit divider stages and the output register.
// A stalled output freezes the back end; the four-entry queue absorbs the
//   front end's items in flight, then in_stall_o rises.
// Reset: coefficients return to identity, all pipelines empty.
`default_nettype none

module homography_point_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] pt_x_i,
  input  wire logic [31:0] pt_y_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      out_x_o,
  output logic [31:0]      out_y_o,
  output logic [31:0]      out_w_o,
  output logic             saturated_o
);

  localparam int unsigned SW = hpt_pkg::SUM_W;
  localparam int unsigned PW = 2 * (SW + FRAC_BITS) + SW + 3;
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
  // Identity matrix
  localparam hpt_pkg::coef_t COEF_RESET = '{h00: ONE, h11: ONE, h22: ONE, default: '0};

  hpt_pkg::coef_t coef_q;
  logic en_f, f_valid, q_full, q_avail, q_pop;
  logic [PW-1:0] f_data, q_data;

  // Coefficient registers, reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (hpt_pkg::cfg_idx_e'(cfg_index_i))
        hpt_pkg::CFG_R0_AB: begin
          coef_q.h00 <= cfg_data_i[63:32];
          coef_q.h01 <= cfg_data_i[31:0];
        end
        hpt_pkg::CFG_R0C_R1A: begin
          coef_q.h02 <= cfg_data_i[63:32];
          coef_q.h10 <= cfg_data_i[31:0];
        end
        hpt_pkg::CFG_R1_BC: begin
          coef_q.h11 <= cfg_data_i[63:32];
          coef_q.h12 <= cfg_data_i[31:0];
        end
        hpt_pkg::CFG_R2_AB: begin
          coef_q.h20 <= cfg_data_i[63:32];
          coef_q.h21 <= cfg_data_i[31:0];
        end
        hpt_pkg::CFG_R2_C: begin
          coef_q.h22 <= cfg_data_i[31:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Front end holds only when its last stage cannot enter a full queue
  assign en_f       = !(f_valid && q_full);
  assign in_stall_o = !en_f;

  hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_f),
    .valid_i (in_valid_i),
    .pt_x_i  (pt_x_i),
    .pt_y_i  (pt_y_i),
    .coef_i  (coef_q),
    .valid_o (f_valid),
    .data_o  (f_data)
  );

  hpt_queue #(.WIDTH(PW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && !q_full),
    .data_i  (f_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .data_o  (q_data)
  );

  hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_avail),
    .data_i      (q_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_w_o     (out_w_o),
    .saturated_o (saturated_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/hpt_checker.sv
// Port-level checks for the homography point transform, bound to the top.
// Depends on hpt_pkg.
`default_nettype none

module hpt_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_stall_i,
  input wire logic [31:0] out_x_i,
  input wire logic [31:0] out_y_i,
  input wire logic [31:0] out_w_i,
  input wire logic        saturated_i
);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i))
    else $error("stalled result changed");

  a_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_w_i == ONE || out_w_i == 32'd0))
    else $error("weight neither 1.0 nor zero");

  a_sat_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |->
      (out_x_i == hpt_pkg::Q_MAX || out_x_i == hpt_pkg::Q_MIN ||
       out_y_i == hpt_pkg::Q_MAX || out_y_i == hpt_pkg::Q_MIN))
    else $error("saturation flag without a clipped coordinate");

endmodule

bind homography_point_transform hpt_checker #(.FRAC_BITS(FRAC_BITS)) u_hpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_x_i     (out_x_o),
  .out_y_i     (out_y_o),
  .out_w_i     (out_w_o),
  .saturated_i (saturated_o)
);

`default_nettype wire
